### hw/rtl/fixed_point_q24_8_alu_assert.svh
// Assertion macros used by the fixed-point ALU RTL.
`ifndef FIXED_POINT_Q24_8_ALU_ASSERT_SVH
`define FIXED_POINT_Q24_8_ALU_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define FPQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fixed-point ALU check failed");

// Next-cycle implication, checked out of reset.
`define FPQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fixed-point ALU check failed");

`endif

### hw/rtl/fpq_pkg.sv
// Shared constants, types and the saturation function of the fixed-point ALU.
package fpq_pkg;

  localparam int WORD_BITS   = 32;
  localparam int FRAC_BITS   = 8;
  localparam int NUM_W       = WORD_BITS + FRAC_BITS;
  localparam int DIV_STEPS   = 8;
  localparam int DIV_STAGES  = (NUM_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int QUO_W       = DIV_STAGES * DIV_STEPS;
  localparam int PROD_W      = 2 * WORD_BITS;
  localparam int MAG_W       = (PROD_W > QUO_W + 1) ? PROD_W : QUO_W + 1;
  localparam int IN_TDATA_W  = ((2 * WORD_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((WORD_BITS + 3 + 7) / 8) * 8;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_LT = 4'd4, OP_GT = 4'd5, OP_LE = 4'd6, OP_GE = 4'd7,
    OP_EQ = 4'd8, OP_NE = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
    OP_INC = 4'd12, OP_DEC = 4'd13, OP_FROM_INT = 4'd14, OP_TO_INT = 4'd15
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_OVF = 2'd1,
    ST_DZ  = 2'd2
  } status_t;

  typedef struct packed {
    opcode_t              op;
    logic [WORD_BITS-1:0] simple;
    logic                 flag;
    logic                 neg;
    logic                 dz;
    logic [WORD_BITS-1:0] dvsr;
  } side_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] rem;
    logic [QUO_W-1:0]     num;
    logic [QUO_W-1:0]     quo;
  } div_t;

  typedef struct packed {
    status_t              st;
    logic [WORD_BITS-1:0] val;
  } sat_t;

  // Applies the sign to a magnitude and clamps it to the word range.
  function automatic sat_t saturate(logic [MAG_W-1:0] m, logic neg);
    logic [MAG_W-1:0]     limit;
    logic [WORD_BITS-1:0] low;
    sat_t                 r;
    limit = neg ? (MAG_W'(1) << (WORD_BITS - 1)) : ((MAG_W'(1) << (WORD_BITS - 1)) - MAG_W'(1));
    low   = m[WORD_BITS-1:0];
    if (m > limit) begin
      r.st  = ST_OVF;
      r.val = neg ? {1'b1, {(WORD_BITS-1){1'b0}}} : {1'b0, {(WORD_BITS-1){1'b1}}};
    end else begin
      r.st  = ST_OK;
      r.val = neg ? (WORD_BITS'(0) - low) : low;
    end
    return r;
  endfunction

endpackage

### hw/rtl/fixed_point_q24_8_alu.sv
// Top level of the pipelined signed Q24.8 fixed-point ALU.
// This block takes one item per cycle and returns one result item for each,
// in order. An item passes an entry register, a multiplier stage that also
// runs the first eight division steps, further stages of eight restoring
// division steps each (five division stages in all for 40 quotient bits), and
// a rounding and saturation stage into the output register, whatever the
// opcode, with a sustained rate of one item per cycle. The whole pipeline
// advances together; it holds only while a result waits in the output
// register and the sink is not ready, so a stall loses and repeats nothing.
// Add, sub, inc, dec and from_int wrap; mul and div round to nearest with
// halves away from zero, saturate on overflow with status 1, and a divide
// by zero gives 0 with status 2.
`include "fixed_point_q24_8_alu_assert.svh"

module fixed_point_q24_8_alu (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [fpq_pkg::IN_TDATA_W-1:0]     in_tdata,   // a_value, b_value
  input  logic [3:0]                         in_tuser,   // opcode
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [fpq_pkg::OUT_TDATA_W-1:0]    out_tdata   // result_value, compare_flag, status
);

  localparam int W  = fpq_pkg::WORD_BITS;
  localparam int NS = fpq_pkg::DIV_STAGES;

  logic adv;

  // Entry stage.
  fpq_pkg::side_t  front_side, s0_side_r;
  logic [W-1:0]    front_maga, s0_maga_r;
  logic            s0_v_r;

  // Multiplier and division stages, indexed 1 to NS.
  logic                        v_r    [1:NS];
  fpq_pkg::side_t              side_r [1:NS];
  logic [fpq_pkg::PROD_W-1:0]  prod_r [1:NS];
  fpq_pkg::div_t               dv_r   [1:NS];
  fpq_pkg::div_t               dv_nxt [1:NS];
  fpq_pkg::div_t               dv_init;

  // Output register.
  logic                 out_v_r;
  logic [W-1:0]         out_result_r, fin_result;
  logic                 out_flag_r, fin_flag;
  fpq_pkg::status_t     out_status_r, fin_status;
  fpq_pkg::opcode_t     out_op_r;

  // Everything moves unless a result is held back by the sink.
  assign adv       = !out_v_r || out_tready;
  assign in_tready = adv;

  fpq_front u_front (
    .op      (fpq_pkg::opcode_t'(in_tuser)),
    .a_value (in_tdata[W-1:0]),
    .b_value (in_tdata[2*W-1:W]),
    .side    (front_side),
    .mag_a   (front_maga)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (adv) begin
      s0_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_side_r <= front_side;
      s0_maga_r <= front_maga;
    end
  end

  // The numerator is |a| scaled by the fraction bits, fed in from the top.
  always_comb begin
    dv_init.rem = '0;
    dv_init.num = fpq_pkg::QUO_W'(s0_maga_r) << fpq_pkg::FRAC_BITS;
    dv_init.quo = '0;
  end

  fpq_div_stage u_div_first (
    .din  (dv_init),
    .dvsr (s0_side_r.dvsr),
    .dout (dv_nxt[1])
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[1] <= 1'b0;
    end else if (adv) begin
      v_r[1] <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[1] <= s0_side_r;
      prod_r[1] <= fpq_pkg::PROD_W'(s0_maga_r) * fpq_pkg::PROD_W'(s0_side_r.dvsr);
      dv_r[1]   <= dv_nxt[1];
    end
  end

  for (genvar k = 2; k <= NS; k++) begin : g_div
    fpq_div_stage u_div (
      .din  (dv_r[k-1]),
      .dvsr (side_r[k-1].dvsr),
      .dout (dv_nxt[k])
    );

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (adv) begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        side_r[k] <= side_r[k-1];
        prod_r[k] <= prod_r[k-1];
        dv_r[k]   <= dv_nxt[k];
      end
    end
  end

  fpq_finish u_finish (
    .side   (side_r[NS]),
    .prod   (prod_r[NS]),
    .dv     (dv_r[NS]),
    .result (fin_result),
    .flag   (fin_flag),
    .status (fin_status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= v_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_result_r <= fin_result;
      out_flag_r   <= fin_flag;
      out_status_r <= fin_status;
      out_op_r     <= side_r[NS].op;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = fpq_pkg::OUT_TDATA_W'({out_status_r, out_flag_r, out_result_r});

  // A held result must block the input side.
  `FPQ_ASSERT_NOW(a_stall_backpressure, out_tvalid && !out_tready, !in_tready)
  // Overflow is only ever reported by mul or div.
  `FPQ_ASSERT_NOW(a_ovf_mul_div, out_v_r && out_status_r == fpq_pkg::ST_OVF,
    out_op_r == fpq_pkg::OP_MUL || out_op_r == fpq_pkg::OP_DIV)
  // The compare flag is only raised by a comparison opcode.
  `FPQ_ASSERT_NOW(a_flag_compare, out_v_r && out_flag_r,
    out_op_r == fpq_pkg::OP_LT || out_op_r == fpq_pkg::OP_GT ||
    out_op_r == fpq_pkg::OP_LE || out_op_r == fpq_pkg::OP_GE ||
    out_op_r == fpq_pkg::OP_EQ || out_op_r == fpq_pkg::OP_NE)
  // A divide by zero leaves a zero result.
  `FPQ_ASSERT_NEXT(a_dz_zero, adv && v_r[NS] && side_r[NS].op == fpq_pkg::OP_DIV &&
    side_r[NS].dz, out_result_r == '0 && out_status_r == fpq_pkg::ST_DZ)

endmodule

### hw/rtl/fpq_front.sv
// Entry stage logic: magnitudes, signs and all operations other than mul and div.
module fpq_front (
  input  fpq_pkg::opcode_t                  op,
  input  logic [fpq_pkg::WORD_BITS-1:0]     a_value,
  input  logic [fpq_pkg::WORD_BITS-1:0]     b_value,
  output fpq_pkg::side_t                    side,
  output logic [fpq_pkg::WORD_BITS-1:0]     mag_a
);

  logic lt_ab, lt_ba;

  assign lt_ab = $signed(a_value) < $signed(b_value);
  assign lt_ba = $signed(b_value) < $signed(a_value);
  assign mag_a = a_value[fpq_pkg::WORD_BITS-1] ? (fpq_pkg::WORD_BITS'(0) - a_value) : a_value;

  always_comb begin
    side.op     = op;
    side.simple = '0;
    side.flag   = 1'b0;
    side.neg    = a_value[fpq_pkg::WORD_BITS-1] ^ b_value[fpq_pkg::WORD_BITS-1];
    side.dvsr   = b_value[fpq_pkg::WORD_BITS-1] ? (fpq_pkg::WORD_BITS'(0) - b_value) : b_value;
    side.dz     = (b_value == '0);
    unique case (op)
      fpq_pkg::OP_ADD:      side.simple = a_value + b_value;
      fpq_pkg::OP_SUB:      side.simple = a_value - b_value;
      fpq_pkg::OP_LT:       side.flag   = lt_ab;
      fpq_pkg::OP_GT:       side.flag   = lt_ba;
      fpq_pkg::OP_LE:       side.flag   = !lt_ba;
      fpq_pkg::OP_GE:       side.flag   = !lt_ab;
      fpq_pkg::OP_EQ:       side.flag   = (a_value == b_value);
      fpq_pkg::OP_NE:       side.flag   = (a_value != b_value);
      fpq_pkg::OP_MIN:      side.simple = lt_ab ? a_value : b_value;
      fpq_pkg::OP_MAX:      side.simple = lt_ba ? a_value : b_value;
      fpq_pkg::OP_INC:      side.simple = a_value + fpq_pkg::WORD_BITS'(1);
      fpq_pkg::OP_DEC:      side.simple = a_value - fpq_pkg::WORD_BITS'(1);
      fpq_pkg::OP_FROM_INT: side.simple = a_value << fpq_pkg::FRAC_BITS;
      fpq_pkg::OP_TO_INT:   side.simple = $signed(a_value) >>> fpq_pkg::FRAC_BITS;
      default:              side.simple = '0;
    endcase
  end

endmodule

### hw/rtl/fpq_div_stage.sv
// A group of restoring division steps, one quotient bit per step.
module fpq_div_stage (
  input  fpq_pkg::div_t                  din,
  input  logic [fpq_pkg::WORD_BITS-1:0]  dvsr,
  output fpq_pkg::div_t                  dout
);

  always_comb begin
    fpq_pkg::div_t              st;
    logic [fpq_pkg::WORD_BITS:0] r2;
    st = din;
    for (int i = 0; i < fpq_pkg::DIV_STEPS; i++) begin
      r2     = {st.rem, st.num[fpq_pkg::QUO_W-1]};
      st.num = st.num << 1;
      st.quo = st.quo << 1;
      if (r2 >= {1'b0, dvsr}) begin
        r2        = r2 - {1'b0, dvsr};
        st.quo[0] = 1'b1;
      end
      st.rem = r2[fpq_pkg::WORD_BITS-1:0];
    end
    dout = st;
  end

endmodule

### hw/rtl/fpq_finish.sv
// Final stage logic: rounding and saturation of mul and div, result selection.
module fpq_finish (
  input  fpq_pkg::side_t                 side,
  input  logic [fpq_pkg::PROD_W-1:0]     prod,
  input  fpq_pkg::div_t                  dv,
  output logic [fpq_pkg::WORD_BITS-1:0]  result,
  output logic                           flag,
  output fpq_pkg::status_t               status
);

  logic [fpq_pkg::PROD_W-1:0] prod_rnd;
  logic [fpq_pkg::MAG_W-1:0]  mul_mag, div_mag;
  logic                       div_up;
  fpq_pkg::sat_t              mul_sat, div_sat;

  assign prod_rnd = prod + (fpq_pkg::PROD_W'(1) << (fpq_pkg::FRAC_BITS - 1));
  assign mul_mag  = fpq_pkg::MAG_W'(prod_rnd >> fpq_pkg::FRAC_BITS);
  // Round away from zero when twice the remainder reaches the divisor.
  assign div_up   = {dv.rem, 1'b0} >= {1'b0, side.dvsr};
  assign div_mag  = fpq_pkg::MAG_W'(dv.quo) + fpq_pkg::MAG_W'(div_up);
  assign mul_sat  = fpq_pkg::saturate(mul_mag, side.neg);
  assign div_sat  = fpq_pkg::saturate(div_mag, side.neg);

  always_comb begin
    result = side.simple;
    flag   = side.flag;
    status = fpq_pkg::ST_OK;
    unique case (side.op)
      fpq_pkg::OP_MUL: begin
        result = mul_sat.val;
        status = mul_sat.st;
      end
      fpq_pkg::OP_DIV: begin
        if (side.dz) begin
          result = '0;
          status = fpq_pkg::ST_DZ;
        end else begin
          result = div_sat.val;
          status = div_sat.st;
        end
      end
      default: begin
        result = side.simple;
      end
    endcase
  end

endmodule

### tb/sv/fixed_point_q24_8_alu_tb.sv
// Self-checking testbench for the pipelined Q24.8 fixed-point ALU.
module fixed_point_q24_8_alu_tb;

  typedef struct {
    fpq_pkg::opcode_t op;
    logic [31:0]      a;
    logic [31:0]      b;
  } alu_item_t;

  typedef struct {
    logic [31:0] value;
    logic        flag;
    logic [1:0]  status;
  } alu_result_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [fpq_pkg::IN_TDATA_W-1:0] in_tdata;
  logic [3:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [fpq_pkg::OUT_TDATA_W-1:0] out_tdata;

  alu_item_t   pending_items[$];
  alu_result_t expected_results[$];
  int          mismatches;
  int          hold_off_cycles;
  bit          drain_request;
  bit          in_taken;
  bit          out_taken;
  int          send_wait;
  int          ready_wait;

  fixed_point_q24_8_alu dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Saturates a signed magnitude into the 32-bit word.
  function automatic alu_result_t clamp_signed(logic [127:0] mag, logic neg);
    alu_result_t r;
    logic [127:0] limit;
    limit = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    r.flag = 1'b0;
    if (mag > limit) begin
      r.status = fpq_pkg::ST_OVF;
      r.value = neg ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      r.status = fpq_pkg::ST_OK;
      r.value = neg ? 32'(0 - mag[31:0]) : mag[31:0];
    end
    return r;
  endfunction

  // Works out the result item that the ALU must give for one input item.
  function automatic alu_result_t alu_outcome(alu_item_t it);
    alu_result_t r;
    logic signed [31:0] sa, sb;
    logic [31:0] ma, mb;
    logic [127:0] prod, num, quo, rem;
    logic neg;
    sa = it.a;
    sb = it.b;
    ma = sa[31] ? 32'(0 - it.a) : it.a;
    mb = sb[31] ? 32'(0 - it.b) : it.b;
    neg = sa[31] ^ sb[31];
    r.value = '0;
    r.flag = 1'b0;
    r.status = fpq_pkg::ST_OK;
    case (it.op)
      fpq_pkg::OP_ADD: r.value = it.a + it.b;
      fpq_pkg::OP_SUB: r.value = it.a - it.b;
      fpq_pkg::OP_MUL: begin
        prod = (128'(ma) * 128'(mb) + 128'(1 << (fpq_pkg::FRAC_BITS - 1)))
               >> fpq_pkg::FRAC_BITS;
        r = clamp_signed(prod, neg);
      end
      fpq_pkg::OP_DIV: begin
        if (mb == 0) begin
          r.status = fpq_pkg::ST_DZ;
        end else begin
          num = 128'(ma) << fpq_pkg::FRAC_BITS;
          quo = num / 128'(mb);
          rem = num % 128'(mb);
          // Halves round away from zero.
          if (rem >= 128'(mb) - rem) quo = quo + 1;
          r = clamp_signed(quo, neg);
        end
      end
      fpq_pkg::OP_LT: r.flag = sa < sb;
      fpq_pkg::OP_GT: r.flag = sa > sb;
      fpq_pkg::OP_LE: r.flag = sa <= sb;
      fpq_pkg::OP_GE: r.flag = sa >= sb;
      fpq_pkg::OP_EQ: r.flag = it.a == it.b;
      fpq_pkg::OP_NE: r.flag = it.a != it.b;
      fpq_pkg::OP_MIN: r.value = (sa < sb) ? it.a : it.b;
      fpq_pkg::OP_MAX: r.value = (sb < sa) ? it.a : it.b;
      fpq_pkg::OP_INC: r.value = it.a + 1;
      fpq_pkg::OP_DEC: r.value = it.a - 1;
      fpq_pkg::OP_FROM_INT: r.value = it.a << fpq_pkg::FRAC_BITS;
      default: r.value = 32'(sa >>> fpq_pkg::FRAC_BITS);
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h, expected %h", what, got, want);
    mismatches++;
  endtask

  // Operand values drawn mostly from the interesting corners.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000 + $urandom_range(0, 3);
      1: return 32'h7fff_ffff - $urandom_range(0, 3);
      2: return 32'(int'($urandom_range(0, 1024)) - 512);
      3: return 32'(int'($urandom_range(0, 65535)) - 32768);
      4: return 32'($urandom_range(0, 3)) << 8;
      default: return $urandom;
    endcase
  endfunction

  // Handshakes seen at the rising edge, for the processes on the falling edge.
  always @(posedge clk) begin
    in_taken  <= rst_n && in_tvalid && in_tready;
    out_taken <= rst_n && out_tvalid && out_tready;
  end

  // Driver: holds each item until it is taken, then waits a drawn number of cycles.
  always @(negedge clk) begin
    alu_item_t it;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= '0;
      send_wait = 0;
    end else if (!in_tvalid || in_taken) begin
      if (send_wait > 0) begin
        send_wait--;
        in_tvalid <= 1'b0;
      end else if (drain_request && expected_results.size() != 0) begin
        // Pause until every result item expected so far has come back.
        in_tvalid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        drain_request = 1'b0;
        it = pending_items.pop_front();
        expected_results.push_back(alu_outcome(it));
        in_tvalid <= 1'b1;
        in_tdata  <= {it.b, it.a};
        in_tuser  <= it.op;
        send_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Counts down the long receiver hold-off once the stimulus starts one.
  always @(negedge clk) begin
    if (hold_off_cycles > 0) hold_off_cycles <= hold_off_cycles - 1;
  end

  // Receiver: waits a drawn number of cycles before taking each result item.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      ready_wait = $urandom_range(0, 7);
    end else if (hold_off_cycles > 0) begin
      out_tready <= 1'b0;
    end else begin
      if (out_taken) ready_wait = $urandom_range(0, 7);
      if (ready_wait > 0) begin
        ready_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Monitor: compares each accepted result item with the oldest expectation.
  always @(posedge clk) begin
    alu_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result item", out_tdata[31:0], 32'h0);
      end else begin
        want = expected_results.pop_front();
        if (out_tdata[31:0] !== want.value)
          report_mismatch("result_value", out_tdata[31:0], want.value);
        if (out_tdata[32] !== want.flag)
          report_mismatch("compare_flag", 32'(out_tdata[32]), 32'(want.flag));
        if (out_tdata[34:33] !== want.status)
          report_mismatch("status", 32'(out_tdata[34:33]), 32'(want.status));
      end
    end
  end

  task automatic queue_item(fpq_pkg::opcode_t op, logic [31:0] a, logic [31:0] b);
    alu_item_t it;
    it.op = op;
    it.a = a;
    it.b = b;
    pending_items.push_back(it);
  endtask

  initial begin : stimulus
    fpq_pkg::opcode_t op;
    mismatches = 0;
    hold_off_cycles = 0;
    drain_request = 1'b0;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed corners: wrap, positive saturation, the negative limit, divide by zero, rounding ties.
    queue_item(fpq_pkg::OP_ADD, 32'h7fff_ffff, 32'h0000_0001);
    queue_item(fpq_pkg::OP_SUB, 32'h8000_0000, 32'h0000_0001);
    queue_item(fpq_pkg::OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
    queue_item(fpq_pkg::OP_MUL, 32'h8000_0000, 32'h0000_0100);
    queue_item(fpq_pkg::OP_MUL, 32'h8000_0000, 32'hffff_ff00);
    queue_item(fpq_pkg::OP_MUL, 32'h0000_0001, 32'h0000_0080);
    queue_item(fpq_pkg::OP_MUL, 32'hffff_ffff, 32'h0000_0080);
    queue_item(fpq_pkg::OP_DIV, 32'h0000_0100, 32'h0000_0000);
    queue_item(fpq_pkg::OP_DIV, 32'h7fff_ffff, 32'h0000_0001);
    queue_item(fpq_pkg::OP_DIV, 32'h8000_0000, 32'hffff_ff00);
    queue_item(fpq_pkg::OP_DIV, 32'h8000_0000, 32'h0000_0100);
    queue_item(fpq_pkg::OP_DIV, 32'h0000_0001, 32'h0000_0200);
    queue_item(fpq_pkg::OP_DIV, 32'hffff_ffff, 32'h0000_0200);
    queue_item(fpq_pkg::OP_LT, 32'h8000_0000, 32'h7fff_ffff);
    queue_item(fpq_pkg::OP_GT, 32'h8000_0000, 32'h7fff_ffff);
    queue_item(fpq_pkg::OP_LE, 32'h0000_0005, 32'h0000_0005);
    queue_item(fpq_pkg::OP_GE, 32'hffff_ffff, 32'h0000_0000);
    queue_item(fpq_pkg::OP_EQ, 32'h1234_5678, 32'h1234_5678);
    queue_item(fpq_pkg::OP_NE, 32'h1234_5678, 32'h1234_5678);
    queue_item(fpq_pkg::OP_MIN, 32'h0000_0007, 32'h0000_0007);
    queue_item(fpq_pkg::OP_MAX, 32'h8000_0000, 32'h7fff_ffff);
    queue_item(fpq_pkg::OP_INC, 32'h7fff_ffff, 32'hffff_ffff);
    queue_item(fpq_pkg::OP_DEC, 32'h8000_0000, 32'h0000_0000);
    queue_item(fpq_pkg::OP_FROM_INT, 32'h00ff_ffff, 32'h0);
    queue_item(fpq_pkg::OP_TO_INT, 32'h8000_00ff, 32'h0);
    while (pending_items.size() != 0) @(negedge clk);

    // Long receiver hold-off while the sender keeps offering items.
    hold_off_cycles = 60;
    for (int i = 0; i < 1850; i++) begin
      op = fpq_pkg::opcode_t'($urandom_range(0, 15));
      queue_item(op, pick_operand(), pick_operand());
      if (i == 900) drain_request = 1'b1;
      if (pending_items.size() > 16) while (pending_items.size() > 4) @(negedge clk);
    end
    while (pending_items.size() != 0 || expected_results.size() != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("fixed_point_q24_8_alu test passed");
    end else begin
      $display("fixed_point_q24_8_alu test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #400000;
    $display("fixed_point_q24_8_alu test failed");
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/fpq_pkg.sv
hw/rtl/fpq_front.sv
hw/rtl/fpq_div_stage.sv
hw/rtl/fpq_finish.sv
hw/rtl/fixed_point_q24_8_alu.sv
tb/sv/fixed_point_q24_8_alu_tb.sv
